// ===== hw/rtl/dwm_pkg.sv =====
// Package: shared types and constants for the decimal word machine.
package dwm_pkg;
   localparam int MemWords = 100000;
   localparam int NumRegs = 10;
   localparam int AddrW = 17;
   localparam int RegIdxW = 4;
   localparam int WordW = 32;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_HALTED = 3'd1, ST_BADADDR = 3'd2,
      ST_BADOP = 3'd3, ST_DIVZERO = 3'd4, ST_STOPPED = 3'd5
   } status_type;

   typedef enum logic [1:0] {MODE_RUN = 2'd0, MODE_HALT = 2'd1, MODE_ERR = 2'd2} mode_type;

   typedef enum logic [3:0] {
      OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4, OP_LOAD = 4'd5,
      OP_STORE = 4'd6, OP_READ = 4'd7, OP_WRITE = 4'd8, OP_BR = 4'd9,
      OP_BRNEG = 4'd10, OP_BRZERO = 4'd11, OP_BRPOS = 4'd12, OP_HALT = 4'd13
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_DECODE, S_DIGITS, S_OPER, S_EXEC, S_DIVWAIT, S_MULWAIT, S_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;
endpackage

// ===== hw/rtl/decimal_word_machine_core_top.sv =====
// Top level: sequencer, register file, word memory and divider of the decimal word machine.
// Decimal word machine core. Each request beat returns one response beat. A load beat
// (tuser 0) is handled in FETCH. A step beat (tuser 1) passes fetch from the single-port
// word memory, DECODE, two registered stages that split the decimal fields (DIGITS, then
// OPER, which issues the operand read) and execute. Multiply adds MULWAIT; divide waits in
// DIVWAIT on the bit-serial divider. Only one beat is in flight, so the next request is taken
// in the cycle after the response beat. Memory reads of never-written words are undefined.
// There is no clearing pass; a request is taken in the first cycle after reset is released.
module decimal_word_machine_core_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address[16:0], data[48:17], zero fill
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status[2:0], has_output[3], output_value[35:4],
                                   // used_data[36], program_counter[53:37], zero fill
);
   import dwm_pkg::*;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [AddrW-1:0] pc_ff, pc_in;
   logic        start_ff, start_in;
   logic [WordW-1:0] regs_ff [NumRegs];
   logic        reg_we;
   logic [WordW-1:0] reg_wdata;

   logic        kind_ff, kind_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;

   // decode registers
   logic [31:0] absw_ff, absw_in;
   logic        wneg_ff, wneg_in;
   logic [5:0]  op_ff, op_in;
   logic [19:0] rem6_ff, rem6_in;
   logic [3:0]  rd_ff, rd_in;
   logic [AddrW-1:0] opnd_ff, opnd_in;
   logic        bad_ff, bad_in;
   logic [31:0] rv_ff, rv_in;
   logic [31:0] prod_ff, prod_in;

   logic [2:0]  st_ff, st_in;
   logic        hout_ff, hout_in, used_ff, used_in;
   logic [31:0] oval_ff, oval_in;

   logic        mem_we;
   logic [AddrW-1:0] mem_addr;
   logic [31:0] mem_wdata, mem_rdata;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [AddrW-1:0] npc;
   logic [63:0] qprod;
   logic [11:0] opq;
   logic [31:0] opbase;
   logic [40:0] rdq;

   dwm_ram #(.Width(WordW), .Depth(MemWords)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata));

   dwm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign npc = (pc_ff == AddrW'(MemWords - 1)) ? '0 : pc_ff + AddrW'(1);

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; pc_in = pc_ff; start_in = start_ff;
      kind_in = kind_ff; addr_in = addr_ff; data_in = data_ff;
      absw_in = absw_ff; wneg_in = wneg_ff; op_in = op_ff; rem6_in = rem6_ff;
      rd_in = rd_ff; opnd_in = opnd_ff; bad_in = bad_ff; rv_in = rv_ff; prod_in = prod_ff;
      st_in = st_ff; hout_in = hout_ff; used_in = used_ff; oval_in = oval_ff;
      mem_we = 1'b0; mem_addr = pc_ff; mem_wdata = data_ff;
      reg_we = 1'b0; reg_wdata = mem_rdata;
      dreq.start = 1'b0; dreq.dividend = rv_ff; dreq.divisor = mem_rdata;
      req_tready = (state_ff == S_IDLE) && !reset;
      qprod = '0; opq = '0; opbase = '0; rdq = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !reset) begin
               kind_in = req_tuser; addr_in = req_tdata[16:0]; data_in = req_tdata[48:17];
               st_in = ST_OK; hout_in = 1'b0; used_in = 1'b0; oval_in = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (!kind_ff) begin
               if (addr_ff < AddrW'(MemWords)) begin
                  mem_we = 1'b1; mem_addr = addr_ff;
                  if (!start_ff) begin
                     pc_in = addr_ff; start_in = 1'b1;
                  end
               end else begin
                  st_in = ST_BADADDR;
               end
               state_in = S_DONE;
            end else if (mode_ff != MODE_RUN) begin
               st_in = ST_STOPPED; state_in = S_DONE;
            end else begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // |w| / 1000000 via reciprocal, exact for |w| < 2^31
            absw_in = mem_rdata[31] ? 32'(-mem_rdata) : mem_rdata;
            wneg_in = mem_rdata[31];
            state_in = S_DIGITS;
         end
         S_DIGITS: begin
            qprod = 64'(absw_ff) * 64'd4503599628;  // ceil(2^52/1e6)
            opq = qprod[63:52];
            opbase = 32'(opq) * 32'd1000000;
            // any opcode above halt saturates so it stays invalid
            op_in = (opq > 12'(OP_HALT)) ? 6'h3f : 6'(opq);
            rem6_in = 20'(absw_ff - opbase);
            state_in = S_OPER;
            // operand stage follows
         end
         S_OPER: begin
            rdq = 41'(rem6_ff) * 41'd1374390;  // floor(x/100000) for x < 1e6
            rd_in = rdq[40:37];
            opnd_in = AddrW'(rem6_ff - 20'(rdq[40:37]) * 20'd100000);
            bad_in = wneg_ff || op_ff == 6'd0 || op_ff > 6'd13 || rdq[40:37] >= 4'(NumRegs);
            // negative nonzero words fail on opcode sign; zero op caught above
            state_in = S_EXEC;
            mem_addr = AddrW'(rem6_ff - 20'(rdq[40:37]) * 20'd100000);
            rv_in = regs_ff[rdq[40:37] >= 4'(NumRegs) ? '0 : rdq[40:37]];
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (bad_ff) begin
               st_in = ST_BADOP; mode_in = MODE_ERR;
            end else begin
               case (op_type'(op_ff[3:0]))
                  OP_ADD: begin reg_we = 1'b1; reg_wdata = rv_ff + mem_rdata; pc_in = npc; end
                  OP_SUB: begin reg_we = 1'b1; reg_wdata = rv_ff - mem_rdata; pc_in = npc; end
                  OP_MUL: begin
                     prod_in = rv_ff * mem_rdata; state_in = S_MULWAIT;
                  end
                  OP_DIV: begin
                     if (mem_rdata == '0) begin
                        st_in = ST_DIVZERO; mode_in = MODE_ERR;
                     end else begin
                        dreq.start = 1'b1; state_in = S_DIVWAIT;
                     end
                  end
                  OP_LOAD: begin reg_we = 1'b1; pc_in = npc; end
                  OP_STORE: begin
                     mem_we = 1'b1; mem_addr = opnd_ff; mem_wdata = rv_ff; pc_in = npc;
                  end
                  OP_READ: begin
                     mem_we = 1'b1; mem_addr = opnd_ff; mem_wdata = data_ff;
                     used_in = 1'b1; pc_in = npc;
                  end
                  OP_WRITE: begin hout_in = 1'b1; oval_in = mem_rdata; pc_in = npc; end
                  OP_BR: pc_in = opnd_ff;
                  OP_BRNEG: pc_in = rv_ff[31] ? opnd_ff : npc;
                  OP_BRZERO: pc_in = (rv_ff == '0) ? opnd_ff : npc;
                  OP_BRPOS: pc_in = (!rv_ff[31] && rv_ff != '0) ? opnd_ff : npc;
                  OP_HALT: begin st_in = ST_HALTED; mode_in = MODE_HALT; end
                  default: begin st_in = ST_BADOP; mode_in = MODE_ERR; end
               endcase
            end
         end
         S_MULWAIT: begin
            reg_we = 1'b1; reg_wdata = prod_ff; pc_in = npc; state_in = S_DONE;
         end
         S_DIVWAIT: begin
            if (drsp.done) begin
               reg_we = 1'b1; reg_wdata = drsp.quot; pc_in = npc; state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; addr_ff <= addr_in; data_ff <= data_in;
      absw_ff <= absw_in; wneg_ff <= wneg_in; op_ff <= op_in; rem6_ff <= rem6_in;
      rd_ff <= rd_in; opnd_ff <= opnd_in; bad_ff <= bad_in; rv_ff <= rv_in; prod_ff <= prod_in;
      st_ff <= st_in; hout_ff <= hout_in; used_ff <= used_in; oval_ff <= oval_in;
      if (reset) begin
         state_ff <= S_IDLE; mode_ff <= MODE_RUN; pc_ff <= '0; start_ff <= 1'b0;
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in; mode_ff <= mode_in; pc_ff <= pc_in; start_ff <= start_in;
         if (reg_we) regs_ff[rd_ff] <= reg_wdata;
      end
   end

   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata = {2'b00, pc_ff, used_ff, oval_ff, hout_ff, st_ff};

   a_one_hot_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(hout_ff && used_ff)) else $error("write and read flagged together");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < AddrW'(MemWords)) else $error("pc out of range");
   a_stopped_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (st_ff == ST_BADOP || st_ff == ST_DIVZERO)) |-> mode_ff == MODE_ERR)
      else $error("error status without stop");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      drsp.busy |-> state_ff == S_DIVWAIT) else $error("divider busy outside wait");
endmodule

// ===== hw/rtl/dwm_ram.sv =====
// Generic single-port RAM with registered read.
module dwm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== hw/rtl/dwm_div.sv =====
// Radix-2 signed divider, truncating toward zero, one quotient bit per cycle.
module dwm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  dwm_pkg::div_req_type      req,
   output dwm_pkg::div_rsp_type      rsp
);
   import dwm_pkg::*;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;
   logic [31:0] a_abs, b_abs;

   always_comb begin
      a_abs = req.dividend[31] ? 32'(-req.dividend) : req.dividend;
      b_abs = req.divisor[31] ? 32'(-req.divisor) : req.divisor;
      shifted = {rem_ff, quo_ff[31]};
      trial = shifted - {1'b0, den_ff};
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (req.start) begin
         rem_in = '0; quo_in = a_abs; den_in = b_abs; cnt_in = 6'd32;
         busy_in = 1'b1; neg_in = req.dividend[31] ^ req.divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0]; quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = neg_ff ? 32'(-quo_ff) : quo_ff;
endmodule
